/* rtl/pstt_pkg.sv */
// Package for the pursuit step block: widths, pipeline depths and the
// sideband record that travels with each item. No dependencies.
package pstt_pkg;

    localparam int COORD_BITS   = 32;
    localparam int LAT_W        = COORD_BITS - 1;
    localparam int LON_W        = COORD_BITS;
    localparam int MAG_W        = COORD_BITS + 1;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int ROOT_W       = MAG_W;
    localparam int REM_W        = ROOT_W + 2;
    localparam int STEP_W       = 24;
    localparam int NUM_W        = STEP_W + MAG_W;
    localparam int SSQ_W        = 2 * STEP_W;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1000);
    localparam logic REG_STEP   = 1'b0;

    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int DIV_STAGES   = MAG_W;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 1;

    typedef struct packed {
        logic signed [LAT_W-1:0] cur_lat;
        logic signed [LON_W-1:0] cur_lon;
        logic signed [LAT_W-1:0] tgt_lat;
        logic signed [LON_W-1:0] tgt_lon;
        logic                    neg_lat;
        logic                    neg_lon;
        logic [NUM_W-1:0]        num_lat;
        logic [NUM_W-1:0]        num_lon;
        logic                    reached;
    } side_t;

endpackage

/* rtl/pursuit_step_toward_target.sv */
// Path: a transaction accepted on start passes through 5 front stages, 33 root
// stages, 33 quotient stages and one output register before it appears on
// done. Throughput: one transaction per cycle; busy stays low, as every
// stage advances each cycle.
// Reset: rst_n clears all valid bits and sets the step register to 1000.
module pursuit_step_toward_target
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [pstt_pkg::LAT_W-1:0] cur_lat,
    input  logic signed [pstt_pkg::LON_W-1:0] cur_lon,
    input  logic signed [pstt_pkg::LAT_W-1:0] tgt_lat,
    input  logic signed [pstt_pkg::LON_W-1:0] tgt_lon,
    output logic                              done,
    output logic signed [pstt_pkg::LAT_W-1:0] new_lat,
    output logic signed [pstt_pkg::LON_W-1:0] new_lon,
    output logic                              reached,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pstt_pkg::APB_AW-1:0]       paddr,
    input  logic [pstt_pkg::APB_DW-1:0]       pwdata,
    output logic [pstt_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    logic [pstt_pkg::STEP_W-1:0]     step_reg;
    logic                            cfg_wr;
    logic                            accept;

    logic                            f_valid;
    logic [pstt_pkg::SQ_W-1:0]       f_sq;
    pstt_pkg::side_t                 f_side;
    logic                            r_valid;
    logic [pstt_pkg::ROOT_W-1:0]     r_root;
    pstt_pkg::side_t                 r_side;
    logic                            d_valid;
    logic [pstt_pkg::MAG_W-1:0]      q_lat, q_lon;
    pstt_pkg::side_t                 d_side;

    logic                            done_reg;
    logic signed [pstt_pkg::LAT_W-1:0] new_lat_reg, new_lat_next;
    logic signed [pstt_pkg::LON_W-1:0] new_lon_reg, new_lon_next;
    logic                            reached_reg;
    logic [pstt_pkg::MAG_W-1:0]      lat_wide, lon_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Hold the step register; write it on a completed write transaction to the step address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pstt_pkg::STEP_RESET;
        end
        else if (cfg_wr && (paddr[2] == pstt_pkg::REG_STEP))
        begin
            step_reg <= pwdata[pstt_pkg::STEP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == pstt_pkg::REG_STEP) ? pstt_pkg::APB_DW'(step_reg) : '0;

    pstt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cur_lat   (cur_lat),
        .cur_lon   (cur_lon),
        .tgt_lat   (tgt_lat),
        .tgt_lon   (tgt_lon),
        .step      (step_reg),
        .out_valid (f_valid),
        .out_sq    (f_sq),
        .out_side  (f_side)
    );

    pstt_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_x      (f_sq),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    pstt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_dist   (r_root),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_q_lat (q_lat),
        .out_q_lon (q_lon),
        .out_side  (d_side)
    );

    // Apply the signed step, or take the target when within one step
    always_comb
    begin
        lat_wide = d_side.neg_lat ? pstt_pkg::MAG_W'(d_side.cur_lat) - q_lat
                                  : pstt_pkg::MAG_W'(d_side.cur_lat) + q_lat;
        lon_wide = d_side.neg_lon ? pstt_pkg::MAG_W'(d_side.cur_lon) - q_lon
                                  : pstt_pkg::MAG_W'(d_side.cur_lon) + q_lon;
        if (d_side.reached)
        begin
            new_lat_next = d_side.tgt_lat;
            new_lon_next = d_side.tgt_lon;
        end
        else
        begin
            new_lat_next = lat_wide[pstt_pkg::LAT_W-1:0];
            new_lon_next = lon_wide[pstt_pkg::LON_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        new_lat_reg <= new_lat_next;
        new_lon_reg <= new_lon_next;
        reached_reg <= d_side.reached;
    end

    assign done    = done_reg;
    assign new_lat = new_lat_reg;
    assign new_lon = new_lon_reg;
    assign reached = reached_reg;

    // Every started transaction completes after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(pstt_pkg::LATENCY) done)
        else $error("started transaction did not complete on time");

    // No result without a start the fixed latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, pstt_pkg::LATENCY))
        else $error("result without a started transaction");

    // Step register changes only on a write transaction
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(step_reg))
        else $error("step register changed without a write");

endmodule

/* rtl/pstt_front.sv */
// Front end: deltas, magnitudes, products, squared distance and the
// within-one-step test, five register stages. Depends on pstt_pkg.
module pstt_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [pstt_pkg::LAT_W-1:0]  cur_lat,
    input  logic signed [pstt_pkg::LON_W-1:0]  cur_lon,
    input  logic signed [pstt_pkg::LAT_W-1:0]  tgt_lat,
    input  logic signed [pstt_pkg::LON_W-1:0]  tgt_lon,
    input  logic [pstt_pkg::STEP_W-1:0]        step,
    output logic                               out_valid,
    output logic [pstt_pkg::SQ_W-1:0]          out_sq,
    output pstt_pkg::side_t                    out_side
);

    logic [pstt_pkg::FRONT_STAGES-1:0] v_reg;

    // stage 1 payload
    logic signed [pstt_pkg::MAG_W-1:0] dlat_reg, dlon_reg;
    logic [pstt_pkg::STEP_W-1:0]       step1_reg;
    pstt_pkg::side_t                   s1_reg;
    // stage 2 payload
    logic [pstt_pkg::MAG_W-1:0]        alat_reg, alon_reg;
    logic [pstt_pkg::STEP_W-1:0]       step2_reg;
    pstt_pkg::side_t                   s2_reg;
    // stage 3 payload
    logic [pstt_pkg::SQ_W-1:0]         sqlat_reg, sqlon_reg;
    logic [pstt_pkg::SSQ_W-1:0]        s2q_reg;
    pstt_pkg::side_t                   s3_reg;
    // stage 4 payload
    logic [pstt_pkg::SQ_W-1:0]         sq_reg;
    logic [pstt_pkg::SSQ_W-1:0]        s2q4_reg;
    pstt_pkg::side_t                   s4_reg;
    // stage 5 payload
    logic [pstt_pkg::SQ_W-1:0]         sq5_reg;
    pstt_pkg::side_t                   s5_reg;

    logic signed [pstt_pkg::MAG_W-1:0] dlat_next, dlon_next;
    pstt_pkg::side_t                   s1_next, s2_next, s3_next, s5_next;

    // Form signed deltas at full width plus one
    always_comb
    begin
        dlat_next = pstt_pkg::MAG_W'(tgt_lat) - pstt_pkg::MAG_W'(cur_lat);
        dlon_next = pstt_pkg::MAG_W'(tgt_lon) - pstt_pkg::MAG_W'(cur_lon);
        s1_next = '0;
        s1_next.cur_lat = cur_lat;
        s1_next.cur_lon = cur_lon;
        s1_next.tgt_lat = tgt_lat;
        s1_next.tgt_lon = tgt_lon;
    end

    // Record signs, then products, then the within-one-step flag
    always_comb
    begin
        s2_next = s1_reg;
        s2_next.neg_lat = dlat_reg[pstt_pkg::MAG_W-1];
        s2_next.neg_lon = dlon_reg[pstt_pkg::MAG_W-1];
        s3_next = s2_reg;
        s3_next.num_lat = pstt_pkg::NUM_W'(step2_reg) * pstt_pkg::NUM_W'(alat_reg);
        s3_next.num_lon = pstt_pkg::NUM_W'(step2_reg) * pstt_pkg::NUM_W'(alon_reg);
        s5_next = s4_reg;
        s5_next.reached = (sq_reg == '0) || (sq_reg < pstt_pkg::SQ_W'(s2q4_reg));
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[pstt_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        dlat_reg  <= dlat_next;
        dlon_reg  <= dlon_next;
        step1_reg <= step;
        s1_reg    <= s1_next;

        alat_reg  <= dlat_reg[pstt_pkg::MAG_W-1] ? pstt_pkg::MAG_W'(-dlat_reg)
                                                 : pstt_pkg::MAG_W'(dlat_reg);
        alon_reg  <= dlon_reg[pstt_pkg::MAG_W-1] ? pstt_pkg::MAG_W'(-dlon_reg)
                                                 : pstt_pkg::MAG_W'(dlon_reg);
        step2_reg <= step1_reg;
        s2_reg    <= s2_next;

        sqlat_reg <= pstt_pkg::SQ_W'(alat_reg) * pstt_pkg::SQ_W'(alat_reg);
        sqlon_reg <= pstt_pkg::SQ_W'(alon_reg) * pstt_pkg::SQ_W'(alon_reg);
        s2q_reg   <= pstt_pkg::SSQ_W'(step2_reg) * pstt_pkg::SSQ_W'(step2_reg);
        s3_reg    <= s3_next;

        sq_reg    <= sqlat_reg + sqlon_reg;
        s2q4_reg  <= s2q_reg;
        s4_reg    <= s3_reg;

        sq5_reg   <= sq_reg;
        s5_reg    <= s5_next;
    end

    assign out_valid = v_reg[pstt_pkg::FRONT_STAGES-1];
    assign out_sq    = sq5_reg;
    assign out_side  = s5_reg;

endmodule

/* rtl/pstt_sqrt.sv */
// Pipelined floor square root, one root bit per register stage.
// Depends on pstt_pkg.
module pstt_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pstt_pkg::SQ_W-1:0]     in_x,
    input  pstt_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [pstt_pkg::ROOT_W-1:0]   out_root,
    output pstt_pkg::side_t               out_side
);

    localparam int N = pstt_pkg::SQRT_STAGES;

    logic                          v_reg    [N];
    logic [pstt_pkg::SQ_W-1:0]     x_reg    [N];
    logic [pstt_pkg::REM_W-1:0]    rem_reg  [N];
    logic [pstt_pkg::ROOT_W-1:0]   root_reg [N];
    pstt_pkg::side_t               side_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic                        v_i;
        logic [pstt_pkg::SQ_W-1:0]   x_i;
        logic [pstt_pkg::REM_W-1:0]  rem_i, rem_sh, trial, rem_next;
        logic [pstt_pkg::ROOT_W-1:0] root_i, root_next;
        pstt_pkg::side_t             side_i;
        logic                        ge;

        if (k == 0)
        begin : g_first
            assign v_i    = in_valid;
            assign x_i    = in_x;
            assign rem_i  = '0;
            assign root_i = '0;
            assign side_i = in_side;
        end
        else
        begin : g_rest
            assign v_i    = v_reg[k-1];
            assign x_i    = x_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        // Bring down two bits and try the next root bit
        always_comb
        begin
            rem_sh = {rem_i[pstt_pkg::REM_W-3:0], x_i[pstt_pkg::SQ_W-1 -: 2]};
            trial  = {root_i, 2'b01};
            ge     = (rem_sh >= trial);
            if (ge)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_i[pstt_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_i[pstt_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= x_i << 2;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_i;
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* rtl/pstt_div.sv */
// Pipelined restoring divider, two lanes (latitude, longitude) sharing one
// divisor, one quotient bit per register stage. Depends on pstt_pkg.
module pstt_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pstt_pkg::ROOT_W-1:0]   in_dist,
    input  pstt_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [pstt_pkg::MAG_W-1:0]    out_q_lat,
    output logic [pstt_pkg::MAG_W-1:0]    out_q_lon,
    output pstt_pkg::side_t               out_side
);

    localparam int N = pstt_pkg::DIV_STAGES;
    localparam int M = pstt_pkg::MAG_W;

    logic                          v_reg    [N];
    logic [pstt_pkg::ROOT_W-1:0]   d_reg    [N];
    logic [M-1:0]                  n_reg    [N][2];
    logic [M-1:0]                  rem_reg  [N][2];
    logic [M-1:0]                  q_reg    [N][2];
    pstt_pkg::side_t               side_reg [N];

    logic [pstt_pkg::NUM_W-1:0]    num_in [2];

    assign num_in[0] = in_side.num_lat;
    assign num_in[1] = in_side.num_lon;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic                        v_i;
        logic [pstt_pkg::ROOT_W-1:0] d_i;
        pstt_pkg::side_t             side_i;

        if (k == 0)
        begin : g_first
            assign v_i    = in_valid;
            assign d_i    = in_dist;
            assign side_i = in_side;
        end
        else
        begin : g_rest
            assign v_i    = v_reg[k-1];
            assign d_i    = d_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [M-1:0] n_i, rem_i, q_i, rem_next;
            logic [M:0]   rem_sh;
            logic         ge;

            if (k == 0)
            begin : g_first
                assign n_i   = num_in[l][M-1:0];
                assign rem_i = M'(num_in[l][pstt_pkg::NUM_W-1:M]);
                assign q_i   = '0;
            end
            else
            begin : g_rest
                assign n_i   = n_reg[k-1][l];
                assign rem_i = rem_reg[k-1][l];
                assign q_i   = q_reg[k-1][l];
            end

            // Bring down one numerator bit and subtract where it fits
            always_comb
            begin
                rem_sh = {rem_i, n_i[M-1]};
                ge     = (rem_sh >= {1'b0, d_i});
                if (ge)
                begin
                    rem_next = M'(rem_sh - {1'b0, d_i});
                end
                else
                begin
                    rem_next = rem_sh[M-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                n_reg[k][l]   <= n_i << 1;
                rem_reg[k][l] <= rem_next;
                q_reg[k][l]   <= {q_i[M-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            d_reg[k]    <= d_i;
            side_reg[k] <= side_i;
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_q_lat = q_reg[N-1][0];
    assign out_q_lon = q_reg[N-1][1];
    assign out_side  = side_reg[N-1];

endmodule
